[hw/rtl/ats_pkg.sv]
// shared types and constants of the alarm table scheduler
package ats_pkg;

	localparam int unsigned ENTRY_COUNT_DEF = 16;
	localparam int unsigned MAX_RESULTS     = 16;
	localparam logic [31:0] MIN_INTERVAL_RST = 32'd60;

	typedef enum logic [1:0] {
		REQ_TICK   = 2'd0,
		REQ_ADD    = 2'd1,
		REQ_DELETE = 2'd2,
		REQ_CANCEL = 2'd3
	} req_type_t;

	localparam logic [1:0] KIND_PERIODIC = 2'd0;
	localparam logic [1:0] KIND_DAILY    = 2'd1;
	localparam logic [1:0] KIND_ONESHOT  = 2'd2;

	localparam logic [2:0] RES_FIRED  = 3'd0;
	localparam logic [2:0] RES_NONE   = 3'd1;
	localparam logic [2:0] RES_ADD    = 3'd2;
	localparam logic [2:0] RES_DELETE = 3'd3;
	localparam logic [2:0] RES_CANCEL = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_ID_ZERO  = 2'd3;

	localparam logic REG_MIN_INTERVAL = 1'b0;
	localparam logic REG_TIME_VALID   = 1'b1;

	typedef struct packed {
		logic [7:0]  id;
		logic [1:0]  kind;
		logic [31:0] interval;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [31:0] last_time;
		logic [16:0] last_day;
	} slot_rec_t;

	localparam int unsigned REC_W = $bits(slot_rec_t);

	typedef struct packed {
		logic       fire;
		logic       arm_only;
		logic       free;
		logic       wr;
		slot_rec_t  rec;
	} eval_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] fid;
		logic [3:0] fslot;
		logic [1:0] status;
		logic [7:0] nid;
		logic [4:0] cnt;
	} res_t;

endpackage

[hw/rtl/ats_ram.sv]
// generic single write port ram with registered read
module ats_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[hw/rtl/ats_eval.sv]
// due check and write-back record for one slot during a tick
module ats_eval
(
	input  ats_pkg::slot_rec_t rec,
	input  logic               armed,
	input  logic [31:0]        now,
	input  logic [4:0]         hour,
	input  logic [5:0]         minute,
	input  logic [16:0]        day,
	output ats_pkg::eval_t     ev
);
	import ats_pkg::*;

	logic [32:0] diff;
	logic        elapsed;

	// shared subtract and compare, a backwards time never elapses
	assign diff    = {1'b0, now} - {1'b0, rec.last_time};
	assign elapsed = !diff[32] && (diff[31:0] >= rec.interval);

	always_comb begin
		ev = '0;
		ev.rec = rec;
		unique case (rec.kind)
			KIND_PERIODIC: ev.fire = !armed || elapsed;
			KIND_DAILY: ev.fire = (rec.hour == hour) && (rec.minute == minute) &&
				(!armed || (rec.last_day != day));
			KIND_ONESHOT: begin
				ev.arm_only = !armed;
				ev.fire     = armed && elapsed;
				ev.free     = armed && elapsed;
			end
			default: ev.fire = 1'b0;
		endcase
		if (ev.arm_only) begin
			ev.rec.last_time = now;
		end else if (ev.fire && rec.kind != KIND_ONESHOT) begin
			ev.rec.last_time = now;
			ev.rec.last_day  = day;
		end
		ev.wr = ev.fire || ev.arm_only;
	end
endmodule

[hw/rtl/alarm_table_scheduler.sv]
// top level of the alarm table scheduler: sequencer, slot flags and output register
//
// usage
//   requests enter on in_valid/in_ready: tick, add, delete by id or cancel all
//   results leave on out_valid/out_ready, one register deep; the last result of a
//   request carries last=1
//   configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
//   index 0 is min_interval_seconds, index 1 is time_valid; cfg_ready is always high
// sequencing
//   one request at a time; in_ready is high only while the sequencer is idle
//   a tick walks the slots one at a time, with a ram read state and then a due check
//   and write-back state for each slot
//   add and cancel walk the slot flags
//   delete walks the slot ram
//   ticks with time_valid low and deletes of id zero go straight to the emit state
// reset
//   all slots free, next id 1, min interval 60, time invalid; no clearing pass
// stalls
//   a fire result waits in a hold register; when the output register is still
//   full the scan pauses on the current slot until the receiver takes it
module alarm_table_scheduler
#(
	parameter int unsigned ENTRY_COUNT = ats_pkg::ENTRY_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [31:0] now_seconds,
	input  logic [4:0]  local_hour,
	input  logic [5:0]  local_minute,
	input  logic [8:0]  day_of_year,
	input  logic [7:0]  year_index,
	input  logic [1:0]  entry_kind,
	input  logic [31:0] period_seconds,
	input  logic [4:0]  target_hour,
	input  logic [5:0]  target_minute,
	input  logic [7:0]  entry_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  result_kind,
	output logic [7:0]  fired_id,
	output logic [3:0]  fired_slot,
	output logic [1:0]  status,
	output logic [7:0]  new_id,
	output logic [4:0]  cancel_count,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	import ats_pkg::*;

	localparam int unsigned IW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
	localparam int unsigned CW = IW + 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(ENTRY_COUNT - 1);
	localparam logic [4:0] MAX_RES = 5'(MAX_RESULTS);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_TRD  = 8'b0000_0010,
		S_TEV  = 8'b0000_0100,
		S_ADD  = 8'b0000_1000,
		S_DRD  = 8'b0001_0000,
		S_DEV  = 8'b0010_0000,
		S_CAN  = 8'b0100_0000,
		S_EMIT = 8'b1000_0000
	} state_t;

	state_t            state_q;
	logic [IW-1:0]     idx_q;
	logic [ENTRY_COUNT-1:0] used_q;
	logic [ENTRY_COUNT-1:0] armed_q;
	logic [7:0]        next_id_q;
	logic [31:0]       min_q;
	logic              tv_q;
	logic [4:0]        n_q;
	logic [CW-1:0]     cnt_q;
	res_t              hold_q;
	logic              hold_valid_q;
	res_t              out_q;
	logic              out_last_q;
	logic              out_valid_q;

	// latched request
	logic [31:0] now_q;
	logic [4:0]  hour_q;
	logic [5:0]  minute_q;
	logic [16:0] day_q;
	logic [1:0]  kind_q;
	logic [31:0] ival_q;
	logic [4:0]  th_q;
	logic [5:0]  tm_q;
	logic [7:0]  del_id_q;

	slot_rec_t   rd_rec;
	slot_rec_t   add_rec;
	logic [REC_W-1:0] rdata;
	logic        we;
	slot_rec_t   wrec;
	eval_t       ev;
	logic        out_free;
	logic        report;
	logic        go;
	logic        at_last;
	logic [31:0] clamped;

	assign rd_rec   = slot_rec_t'(rdata);
	assign out_free = !out_valid_q || out_ready;
	assign at_last  = (idx_q == LAST_IDX);
	assign report   = ev.fire && (n_q < MAX_RES);
	// a new fire result needs the hold register emptied into the output first
	assign go       = !(report && hold_valid_q && !out_free);

	ats_eval u_eval (
		.rec    (rd_rec),
		.armed  (armed_q[idx_q]),
		.now    (now_q),
		.hour   (hour_q),
		.minute (minute_q),
		.day    (day_q),
		.ev     (ev)
	);

	// interval clamp for periodic and one-shot adds
	always_comb begin
		clamped = (ival_q < min_q) ? min_q : ival_q;
		add_rec = '0;
		add_rec.id   = next_id_q;
		add_rec.kind = kind_q;
		if (kind_q == KIND_PERIODIC || kind_q == KIND_ONESHOT) begin
			add_rec.interval = clamped;
		end
		if (kind_q == KIND_DAILY) begin
			add_rec.hour   = th_q;
			add_rec.minute = tm_q;
		end
	end

	always_comb begin
		we   = 1'b0;
		wrec = add_rec;
		if (state_q == S_TEV) begin
			we   = go && ev.wr;
			wrec = ev.rec;
		end else if (state_q == S_ADD) begin
			we = !used_q[idx_q];
		end
	end

	ats_ram #(
		.WIDTH (REC_W),
		.DEPTH (ENTRY_COUNT)
	) u_slots (
		.clk   (clk),
		.we    (we),
		.waddr (idx_q),
		.wdata (wrec),
		.raddr (idx_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			used_q       <= '0;
			armed_q      <= '0;
			next_id_q    <= 8'd1;
			min_q        <= MIN_INTERVAL_RST;
			tv_q         <= 1'b0;
			n_q          <= '0;
			cnt_q        <= '0;
			hold_q       <= '0;
			hold_valid_q <= 1'b0;
			out_q        <= '0;
			out_last_q   <= 1'b0;
			out_valid_q  <= 1'b0;
			now_q        <= '0;
			hour_q       <= '0;
			minute_q     <= '0;
			day_q        <= '0;
			kind_q       <= '0;
			ival_q       <= '0;
			th_q         <= '0;
			tm_q         <= '0;
			del_id_q     <= '0;
		end else begin
			// configuration writes, taken at any time
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_MIN_INTERVAL: min_q <= cfg_data;
					REG_TIME_VALID:   tv_q  <= cfg_data[0];
					default:          tv_q  <= tv_q;
				endcase
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						now_q    <= now_seconds;
						hour_q   <= local_hour;
						minute_q <= local_minute;
						day_q    <= {year_index, day_of_year};
						kind_q   <= entry_kind;
						ival_q   <= period_seconds;
						th_q     <= target_hour;
						tm_q     <= target_minute;
						del_id_q <= entry_id;
						idx_q    <= '0;
						n_q      <= '0;
						cnt_q    <= '0;
						hold_q   <= '0;
						unique case (req_type_t'(req_type))
							REQ_TICK: begin
								if (!tv_q) begin
									// ticks are ignored until time is synchronized
									hold_q.kind  <= RES_NONE;
									hold_valid_q <= 1'b1;
									state_q      <= S_EMIT;
								end else begin
									state_q <= S_TRD;
								end
							end
							REQ_ADD: state_q <= S_ADD;
							REQ_DELETE: begin
								if (entry_id == 8'd0) begin
									hold_q.kind   <= RES_DELETE;
									hold_q.status <= ST_ID_ZERO;
									hold_valid_q  <= 1'b1;
									state_q       <= S_EMIT;
								end else begin
									state_q <= S_DRD;
								end
							end
							REQ_CANCEL: state_q <= S_CAN;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_TRD: state_q <= S_TEV;
				S_TEV: begin
					if (used_q[idx_q] && go) begin
						if (ev.wr) begin
							armed_q[idx_q] <= 1'b1;
						end
						if (ev.free) begin
							used_q[idx_q] <= 1'b0;
						end
						if (report) begin
							// older fire result moves on, the new one waits for last
							if (hold_valid_q) begin
								out_q       <= hold_q;
								out_last_q  <= 1'b0;
								out_valid_q <= 1'b1;
							end
							hold_q       <= '0;
							hold_q.kind  <= RES_FIRED;
							hold_q.fid   <= rd_rec.id;
							hold_q.fslot <= 4'(idx_q);
							hold_valid_q <= 1'b1;
							n_q          <= n_q + 5'd1;
						end
					end
					if (!used_q[idx_q] || go) begin
						if (at_last) begin
							if (!(hold_valid_q || (used_q[idx_q] && report))) begin
								hold_q      <= '0;
								hold_q.kind <= RES_NONE;
							end
							hold_valid_q <= 1'b1;
							state_q      <= S_EMIT;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_TRD;
						end
					end
				end
				S_ADD: begin
					if (!used_q[idx_q]) begin
						used_q[idx_q]  <= 1'b1;
						armed_q[idx_q] <= 1'b0;
						hold_q.kind    <= RES_ADD;
						hold_q.nid     <= next_id_q;
						next_id_q      <= (next_id_q == 8'hFF) ? 8'd1 : next_id_q + 8'd1;
						hold_valid_q   <= 1'b1;
						state_q        <= S_EMIT;
					end else if (at_last) begin
						hold_q.kind   <= RES_ADD;
						hold_q.status <= ST_FULL;
						hold_valid_q  <= 1'b1;
						state_q       <= S_EMIT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_DRD: state_q <= S_DEV;
				S_DEV: begin
					if (used_q[idx_q] && rd_rec.id == del_id_q) begin
						used_q[idx_q] <= 1'b0;
						hold_q.kind   <= RES_DELETE;
						hold_valid_q  <= 1'b1;
						state_q       <= S_EMIT;
					end else if (at_last) begin
						hold_q.kind   <= RES_DELETE;
						hold_q.status <= ST_NOT_FOUND;
						hold_valid_q  <= 1'b1;
						state_q       <= S_EMIT;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_DRD;
					end
				end
				S_CAN: begin
					used_q[idx_q] <= 1'b0;
					if (at_last) begin
						hold_q.kind  <= RES_CANCEL;
						hold_q.cnt   <= 5'(cnt_q + CW'(used_q[idx_q]));
						hold_valid_q <= 1'b1;
						state_q      <= S_EMIT;
					end else begin
						cnt_q <= cnt_q + CW'(used_q[idx_q]);
						idx_q <= idx_q + 1'b1;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_q        <= hold_q;
						out_last_q   <= 1'b1;
						out_valid_q  <= 1'b1;
						hold_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready     = (state_q == S_IDLE);
	assign cfg_ready    = 1'b1;
	assign out_valid    = out_valid_q;
	assign result_kind  = out_q.kind;
	assign fired_id     = out_q.fid;
	assign fired_slot   = out_q.fslot;
	assign status       = out_q.status;
	assign new_id       = out_q.nid;
	assign cancel_count = out_q.cnt;
	assign last         = out_last_q;

	// the hold register is always drained before the sequencer goes idle
	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !hold_valid_q)
		else $error("hold register valid while idle");

	// no more fire results than the cap
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= MAX_RES)
		else $error("fire result count over cap");

	// a fire result is only pushed as non-last while the scan is running
	a_push: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_last_q) |-> (state_q != S_IDLE))
		else $error("non-last result with no request in progress");

	// an accepted request always leaves idle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q != S_IDLE))
		else $error("request accepted but sequencer idle");

endmodule
